FILE: design/sobm_pkg.sv
// Shared types, constants and arithmetic helpers for the Sobel edge magnitude block.
`default_nettype none

package sobm_pkg;

    // Frame size limits and derived counter widths.
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned MIN_DIM    = 3;
    localparam int unsigned FIRST_INNER = 2;

    // Configuration port.
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned CFG_DW   = 12;
    localparam int unsigned CFG_AW   = 2;
    localparam logic [CFG_AW-1:0] CFG_IMG_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMG_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_COLOR_MODE = 2'd2;
    localparam logic [DIM_W-1:0]  RST_IMG_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMG_HEIGHT = 12'd480;

    // Compare width covers the larger counter plus one carry bit and the register width.
    localparam int unsigned MAX_CW = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int unsigned CMP_W  = ((MAX_CW > DIM_W) ? MAX_CW : DIM_W) + 1;

    // Output coordinates have a fixed width.
    localparam int unsigned COORD_W = 11;

    // Gray conversion: sum = 299 R + 587 G + 114 B, gray = floor(sum / 1000).
    localparam int unsigned GRAY_WR    = 299;
    localparam int unsigned GRAY_WG    = 587;
    localparam int unsigned GRAY_WB    = 114;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned GRAY_SHIFT = 28;
    localparam int unsigned RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;

    // Queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Magnitude arithmetic.
    localparam int unsigned GRAD_W = 11;
    localparam int unsigned SQ_W   = 21;
    localparam int unsigned RAD_W  = 16;
    localparam int unsigned RES_W  = 17;
    localparam int unsigned ROOT_STEPS = 4;
    localparam int unsigned ROOT_TOP_HI = 14;
    localparam int unsigned ROOT_TOP_LO = 6;
    localparam logic [7:0]  MAG_SAT = 8'hFF;

    typedef logic [7:0] t_px;

    // Neighborhood of one interior center (center pixel is not needed) and its position.
    typedef struct packed {
        t_px p00;
        t_px p01;
        t_px p02;
        t_px p10;
        t_px p12;
        t_px p20;
        t_px p21;
        t_px p22;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_q_item;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RES_W-1:0] res;
    } t_root_st;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned hi);
        if (32'(v) < MIN_DIM) begin
            return CMP_W'(MIN_DIM);
        end
        if (32'(v) > hi) begin
            return CMP_W'(hi);
        end
        return CMP_W'(v);
    endfunction

    // Division by 1000 as a reciprocal multiply; exact for every sum below 255001.
    function automatic t_px gray_of(input logic [SUM_W-1:0] sum);
        logic [SUM_W+RECIP_W-1:0] prod;
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(GRAY_RECIP);
        return prod[GRAY_SHIFT+7:GRAY_SHIFT];
    endfunction

    // A few steps of the bit-pair square root, starting at bit position top.
    function automatic t_root_st root_steps(input t_root_st s, input int unsigned top);
        t_root_st         t;
        logic [RES_W-1:0] bitv;
        logic [RES_W-1:0] trial;
        t = s;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            bitv  = RES_W'(1) << (top - 2 * k);
            trial = t.res + bitv;
            if (RES_W'(t.rem) >= trial) begin
                t.rem = RAD_W'(RES_W'(t.rem) - trial);
                t.res = (t.res >> 1) + bitv;
            end else begin
                t.res = t.res >> 1;
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: design/sobm_queue.sv
// Short queue that decouples the pixel front from the magnitude back.
`default_nettype none

module sobm_queue import sobm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_q_item      o_item
);

    t_q_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

FILE: design/sobm_front.sv
// Pixel front: position tracking, gray conversion, line stores and the 3x3 window.
`default_nettype none

module sobm_front import sobm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_px              i_red,
    input  wire t_px              i_green,
    input  wire t_px              i_blue,
    input  wire logic [CMP_W-1:0] i_width,
    input  wire logic [CMP_W-1:0] i_height,
    input  wire logic             i_color_mode,
    output logic                  o_push,
    input  wire logic             i_full,
    output t_q_item               o_item
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CMP_W-1:0] pos_col, pos_row, adv_col, adv_row;
    logic             accept, adv1;

    // Stage 0 holds the accepted pixel while the line store read is in flight.
    logic             r_v0;
    logic [COL_W-1:0] r_s0_col;
    logic [ROW_W-1:0] r_s0_row;
    logic [SUM_W-1:0] r_sum;
    t_px              r_red;
    logic             r_mode;
    logic             r_emit;
    logic             r_last;

    t_px r_store_a [MAX_WIDTH];
    t_px r_store_b [MAX_WIDTH];
    t_px r_above1, r_above2;

    t_px r_top1, r_top2, r_mid1, r_mid2, r_bot1, r_bot2;
    t_px gray;

    assign adv1    = r_v0 && (!r_emit || !i_full);
    assign o_ready = i_rst_n && (!r_v0 || adv1);
    assign accept  = i_valid && o_ready;
    assign o_push  = r_v0 && r_emit && !i_full;

    // A stored position past a newly written size wraps before it is used.
    always_comb begin
        pos_col = CMP_W'(r_col);
        pos_row = CMP_W'(r_row);
        if (pos_col >= i_width) begin
            pos_col = '0;
            pos_row = pos_row + 1'b1;
        end
        if (pos_row >= i_height) begin
            pos_row = '0;
        end
        adv_col = pos_col + 1'b1;
        adv_row = pos_row;
        if (adv_col >= i_width) begin
            adv_col = '0;
            adv_row = pos_row + 1'b1;
            if (adv_row >= i_height) begin
                adv_row = '0;
            end
        end
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_col = COL_W'(adv_col);
            n_row = ROW_W'(adv_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v0  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_v0 <= 1'b1;
            end else if (adv1) begin
                r_v0 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_col <= COL_W'(pos_col);
            r_s0_row <= ROW_W'(pos_row);
            r_sum    <= SUM_W'(GRAY_WR * 32'(i_red) + GRAY_WG * 32'(i_green)
                               + GRAY_WB * 32'(i_blue));
            r_red    <= i_red;
            r_mode   <= i_color_mode;
            r_emit   <= (pos_row >= CMP_W'(FIRST_INNER)) && (pos_col >= CMP_W'(FIRST_INNER));
            r_last   <= (pos_row == i_height - 1'b1) && (pos_col == i_width - 1'b1);
        end
    end

    // Consecutive pixels never share a column, so a read and the write of the
    // previous pixel never hit the same entry.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above1 <= r_store_a[COL_W'(pos_col)];
            r_above2 <= r_store_b[COL_W'(pos_col)];
        end
    end

    assign gray = r_mode ? gray_of(r_sum) : r_red;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_store_a[r_s0_col] <= gray;
            r_store_b[r_s0_col] <= r_above1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top1 <= '0;
            r_top2 <= '0;
            r_mid1 <= '0;
            r_mid2 <= '0;
            r_bot1 <= '0;
            r_bot2 <= '0;
        end else if (adv1) begin
            r_top1 <= r_top2;
            r_top2 <= r_above2;
            r_mid1 <= r_mid2;
            r_mid2 <= r_above1;
            r_bot1 <= r_bot2;
            r_bot2 <= gray;
        end
    end

    always_comb begin
        o_item.p00  = r_top1;
        o_item.p01  = r_top2;
        o_item.p02  = r_above2;
        o_item.p10  = r_mid1;
        o_item.p12  = r_above1;
        o_item.p20  = r_bot1;
        o_item.p21  = r_bot2;
        o_item.p22  = gray;
        o_item.row  = COORD_W'(r_s0_row - 1'b1);
        o_item.col  = COORD_W'(r_s0_col - 1'b1);
        o_item.last = r_last;
    end

endmodule

`default_nettype wire

FILE: design/sobm_back.sv
// Magnitude back: Sobel sums, squared norm, pipelined square root and output register.
`default_nettype none

module sobm_back import sobm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_pop,
    input  wire t_q_item      i_item,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [COORD_W-1:0] o_row,
    output logic [COORD_W-1:0] o_col,
    output t_px               o_mag,
    output logic              o_last
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [COORD_W-1:0] r_row1, r_row2, r_row3, r_row4;
    logic [COORD_W-1:0] r_col1, r_col2, r_col3, r_col4;
    logic               r_last1, r_last2, r_last3, r_last4;

    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_sat3;
    t_root_st                 r_root3;
    t_px                      r_mag4;

    logic [GRAD_W-2:0]          gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [2*GRAD_W-1:0] gx2, gy2;
    t_root_st                   root_in, root_hi, root_lo;

    assign rdy4  = !r_v4 || i_ready;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        gx_pos = (GRAD_W-1)'(i_item.p02) + (GRAD_W-1)'({i_item.p12, 1'b0})
               + (GRAD_W-1)'(i_item.p22);
        gx_neg = (GRAD_W-1)'(i_item.p00) + (GRAD_W-1)'({i_item.p10, 1'b0})
               + (GRAD_W-1)'(i_item.p20);
        gy_pos = (GRAD_W-1)'(i_item.p20) + (GRAD_W-1)'({i_item.p21, 1'b0})
               + (GRAD_W-1)'(i_item.p22);
        gy_neg = (GRAD_W-1)'(i_item.p00) + (GRAD_W-1)'({i_item.p01, 1'b0})
               + (GRAD_W-1)'(i_item.p02);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_gx    <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            r_gy    <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
            r_row1  <= i_item.row;
            r_col1  <= i_item.col;
            r_last1 <= i_item.last;
        end
    end

    assign gx2 = r_gx * r_gx;
    assign gy2 = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_sq    <= SQ_W'(gx2[SQ_W-2:0]) + SQ_W'(gy2[SQ_W-2:0]);
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_last2 <= r_last1;
        end
    end

    // A squared norm of 65536 or more has a root of at least 256 and saturates.
    always_comb begin
        root_in.rem = r_sq[RAD_W-1:0];
        root_in.res = '0;
        root_hi     = root_steps(root_in, ROOT_TOP_HI);
        root_lo     = root_steps(r_root3, ROOT_TOP_LO);
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_root3 <= root_hi;
            r_sat3  <= (r_sq[SQ_W-1:RAD_W] != '0);
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_last3 <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_mag4  <= r_sat3 ? MAG_SAT : root_lo.res[7:0];
            r_row4  <= r_row3;
            r_col4  <= r_col3;
            r_last4 <= r_last3;
        end
    end

    assign o_valid = r_v4;
    assign o_row   = r_row4;
    assign o_col   = r_col4;
    assign o_mag   = r_mag4;
    assign o_last  = r_last4;

endmodule

`default_nettype wire

FILE: design/sobel_edge_magnitude.sv
// Top level of the Sobel edge magnitude block: configuration registers and stream ports.
// A result is registered in front stage 0, the queue, then the back's gradient, norm, root and output stages.
// Throughput: one pixel per cycle; the input stalls only when the 4-entry queue is full,
// which happens only under sustained output backpressure.
// Border pixels produce no result, so results come out at a lower rate than pixels go in.
// Reset (synchronous, active low) clears the position counters, window, queue and pipeline
// valids and loads width 640, height 480 and color mode; line stores are not cleared.
`default_nettype none

module sobel_edge_magnitude import sobm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [23:0]       i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,   // center_row[10:0], center_col[21:11],
                                                     // magnitude[29:22], zero[31:30]
    output logic                   o_m_axis_tlast,   // frame_end
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_img_width;
    logic [DIM_W-1:0] r_img_height;
    logic             r_color_mode;
    logic [CMP_W-1:0] width_c, height_c;

    logic               q_push, q_full, q_pop, q_valid;
    t_q_item            q_in, q_out;
    logic [COORD_W-1:0] out_row, out_col;
    t_px                out_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RST_IMG_WIDTH;
            r_img_height <= RST_IMG_HEIGHT;
            r_color_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMG_HEIGHT: r_img_height <= i_cfg_data[DIM_W-1:0];
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                default:        r_color_mode <= r_color_mode;
            endcase
        end
    end

    assign width_c  = clamp_dim(r_img_width, MAX_WIDTH);
    assign height_c = clamp_dim(r_img_height, MAX_HEIGHT);

    sobm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_red        (i_s_axis_tdata[7:0]),
        .i_green      (i_s_axis_tdata[15:8]),
        .i_blue       (i_s_axis_tdata[23:16]),
        .i_width      (width_c),
        .i_height     (height_c),
        .i_color_mode (r_color_mode),
        .o_push       (q_push),
        .i_full       (q_full),
        .o_item       (q_in)
    );

    sobm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    sobm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (q_out),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_row   (out_row),
        .o_col   (out_col),
        .o_mag   (out_mag),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_mag, out_col, out_row};

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the Sobel edge magnitude block with a pixel-by-pixel predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sobm_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned RANDOM_ITEMS  = 480;
    localparam int unsigned MAX_REPORTS   = 10;

    localparam logic [CFG_AW-1:0] REG_ORDER [3] = '{CFG_IMG_WIDTH, CFG_IMG_HEIGHT,
                                                    CFG_COLOR_MODE};

    // Words are {blue, green, red}; the frame is 4x4 with hard edges between rows.
    localparam logic [23:0] DIRECTED_COLOR [16] = '{
        24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF
    };
    localparam logic [7:0] DIRECTED_GRAY [9] = '{
        8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128
    };

    typedef enum int {PX_NOISE, PX_BINARY, PX_RAMP, PX_SPECKLE} t_px_style;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_px                mag;
        logic               last;
    } t_edge_px;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [23:0]       s_tdata = '0;
    logic              m_tready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic [31:0]       m_tdata;
    logic              m_tlast;

    // Predictor state, a copy of what the block holds.
    t_px              row_above  [MAX_WIDTH];
    t_px              row_above2 [MAX_WIDTH];
    t_px              nbhd [3][3];
    int unsigned      px_col;
    int unsigned      px_row;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic             cfg_color;

    t_edge_px    magnitudes_due [$];
    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0;
    bit          quiet = 1'b0;
    bit          sender_steady = 1'b0;
    bit          long_hold_req = 1'b0;

    sobel_edge_magnitude u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb NOT OK");
        $finish;
    end

    function automatic int unsigned limit_size(input logic [DIM_W-1:0] v,
                                               input int unsigned hi);
        if (v < 3) begin
            return 3;
        end
        return (v > hi) ? hi : int'(v);
    endfunction

    // Largest root whose square fits, with anything from 255 up saturated.
    function automatic t_px edge_strength(input int unsigned sq);
        int unsigned root;
        int unsigned trial;
        if (sq >= 65025) begin
            return 8'hFF;
        end
        root = 0;
        for (int b = 7; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        return t_px'(root);
    endfunction

    function automatic void predict_edge(input logic [23:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned row;
        int unsigned col;
        t_px         gray;
        t_px         up1;
        t_px         up2;
        int          gx;
        int          gy;
        t_edge_px    res;
        w = limit_size(cfg_width, MAX_WIDTH);
        h = limit_size(cfg_height, MAX_HEIGHT);
        // A size change may leave the position outside the frame; wrap it first.
        if (px_col >= w) begin
            px_col = 0;
            px_row++;
        end
        if (px_row >= h) begin
            px_row = 0;
        end
        col = px_col;
        row = px_row;
        if (cfg_color) begin
            gray = t_px'((299 * int'(px[7:0]) + 587 * int'(px[15:8])
                          + 114 * int'(px[23:16])) / 1000);
        end else begin
            gray = px[7:0];
        end
        up1 = row_above[col];
        up2 = row_above2[col];
        row_above2[col] = up1;
        row_above[col]  = gray;
        for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = up2;
        nbhd[1][2] = up1;
        nbhd[2][2] = gray;
        px_col++;
        if (px_col >= w) begin
            px_col = 0;
            px_row++;
            if (px_row >= h) begin
                px_row = 0;
            end
        end
        if (row >= 2 && col >= 2) begin
            gx = int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2])
               - int'(nbhd[0][0]) - 2 * int'(nbhd[1][0]) - int'(nbhd[2][0]);
            gy = int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2])
               - int'(nbhd[0][0]) - 2 * int'(nbhd[0][1]) - int'(nbhd[0][2]);
            res.row  = COORD_W'(row - 1);
            res.col  = COORD_W'(col - 1);
            res.mag  = edge_strength(gx * gx + gy * gy);
            res.last = (row == h - 1) && (col == w - 1);
            magnitudes_due.push_back(res);
        end
    endfunction

    function automatic logic [23:0] pick_pixel(input t_px_style style);
        t_px v;
        case (style)
            PX_NOISE: begin
                return 24'($urandom);
            end
            PX_BINARY: begin
                return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                        {8{1'($urandom_range(0, 1))}}};
            end
            PX_RAMP: begin
                v = t_px'(px_col * 9 + px_row * 13 + $urandom_range(0, 2));
                return {v, v, v};
            end
            default: begin
                v = ($urandom_range(0, 9) == 0) ? t_px'($urandom) : 8'd40;
                return {v, v, v};
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        if (!quiet && !sender_steady && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_edge(px);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned n, input t_px_style style);
        repeat (n) send_pixel(pick_pixel(style));
    endtask

    // Sends until the position is back at the top left corner of a frame.
    task automatic finish_frame(input t_px_style style);
        do begin
            send_pixel(pick_pixel(style));
        end while (px_col != 0 || px_row != 0);
    endtask

    // The sender pauses until every result is out, then all registers are written.
    task automatic configure(input int unsigned w, input int unsigned h, input bit mode);
        logic [CFG_DW-1:0] vals [3];
        vals[0] = CFG_DW'(w);
        vals[1] = CFG_DW'(h);
        vals[2] = CFG_DW'(mode);
        s_tvalid <= 1'b0;
        while (magnitudes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int k = 0; k < 3; k++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= REG_ORDER[k];
            cfg_data <= vals[k];
            @(posedge clk);
            case (REG_ORDER[k])
                CFG_IMG_WIDTH:  cfg_width  = vals[k];
                CFG_IMG_HEIGHT: cfg_height = vals[k];
                CFG_COLOR_MODE: cfg_color  = vals[k][0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_color_directed();
        configure(4, 4, 1'b1);
        for (int i = 0; i < 16; i++) begin
            send_pixel(DIRECTED_COLOR[i]);
        end
    endtask

    task automatic test_gray_directed();
        configure(3, 3, 1'b0);
        for (int i = 0; i < 9; i++) begin
            send_pixel({16'($urandom), DIRECTED_GRAY[i]});
        end
    endtask

    // Out-of-range sizes saturate: a short height, a narrow width, both at zero, and an
    // oversized frame that is left early by shrinking the width. The first frame also
    // fills every line store column that later width growth reaches.
    task automatic test_size_extremes();
        configure(48, 2, 1'b0);
        finish_frame(PX_NOISE);
        configure(1, 12, 1'b1);
        finish_frame(PX_BINARY);
        configure(0, 0, 1'b1);
        finish_frame(PX_NOISE);
        configure(4095, 4095, 1'b1);
        send_pixels(40, PX_SPECKLE);
        configure(2, 3, 1'b1);
        finish_frame(PX_SPECKLE);
    endtask

    task automatic test_midframe_resize();
        // Width shrinks below the current column: wraps to the next row.
        configure(8, 6, 1'b1);
        send_pixels(30, PX_NOISE);
        configure(5, 6, 1'b1);
        finish_frame(PX_NOISE);
        // Height shrinks below the current row: wraps to row zero.
        configure(6, 8, 1'b0);
        send_pixels(30, PX_BINARY);
        configure(6, 4, 1'b0);
        finish_frame(PX_BINARY);
        // Width grows in the middle of a row.
        configure(6, 6, 1'b1);
        send_pixels(15, PX_RAMP);
        configure(10, 6, 1'b1);
        finish_frame(PX_RAMP);
    endtask

    task automatic test_output_backpressure();
        configure(16, 8, 1'b1);
        sender_steady = 1'b1;
        long_hold_req = 1'b1;
        finish_frame(PX_NOISE);
        sender_steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned first;
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        t_px_style   style;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_ITEMS) begin
            quiet = (pixels_sent - first) > (RANDOM_ITEMS * 4) / 5;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 20);
            h = $urandom_range(0, 8);
            style = t_px_style'($urandom_range(0, 3));
            configure(w, h, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, limit_size(DIM_W'(w), MAX_WIDTH)
                                        * limit_size(DIM_W'(h), MAX_HEIGHT) - 1);
                send_pixels(cut, style);
                configure($urandom_range(0, 24), $urandom_range(0, 8), 1'($urandom_range(0, 1)));
            end
            finish_frame(style);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold when a test asks for it.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                hold_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_edge_px want;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                if (magnitudes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result transfer with none expected, data %h last %b",
                                 $realtime, m_tdata, m_tlast);
                    end
                end else begin
                    want = magnitudes_due.pop_front();
                    if (m_tdata[10:0] !== want.row || m_tdata[21:11] !== want.col
                        || m_tdata[29:22] !== want.mag || m_tdata[31:30] !== 2'b00
                        || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: expected row %0d col %0d mag %0d last %0d, ",
                                   $realtime, want.row, want.col, want.mag, want.last);
                            $display("got row %0d col %0d mag %0d last %0d pad %0d",
                                     m_tdata[10:0], m_tdata[21:11], m_tdata[29:22],
                                     m_tlast, m_tdata[31:30]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                nbhd[i][j] = '0;
            end
        end
        px_col     = 0;
        px_row     = 0;
        cfg_width  = RST_IMG_WIDTH;
        cfg_height = RST_IMG_HEIGHT;
        cfg_color  = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_color_directed();
        test_gray_directed();
        test_size_extremes();
        test_midframe_resize();
        test_output_backpressure();
        test_random_frames();
        s_tvalid <= 1'b0;
        while (magnitudes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatches == 0 && magnitudes_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/sobm_pkg.sv
design/sobm_queue.sv
design/sobm_front.sv
design/sobm_back.sv
design/sobel_edge_magnitude.sv
tb/tb.sv
